// ===== hdl/cie_pkg.sv =====
package cie_pkg;

    localparam int ADDR_BITS = 16;
    localparam int REG_COUNT = 16;
    localparam int MEM_SIZE = 1 << ADDR_BITS;
    localparam int CSR_COUNT = 3;

    localparam logic [31:0] START_RESET = 32'h4000_0000;
    localparam logic [31:0] CAUSE_SWI = 32'd4;
    localparam logic [3:0] SP_IDX = 4'(REG_COUNT - 2);
    localparam logic [3:0] PC_IDX = 4'(REG_COUNT - 1);
    localparam logic [1:0] CSR_STATUS = 2'd0;
    localparam logic [1:0] CSR_HANDLER = 2'd1;
    localparam logic [1:0] CSR_CAUSE = 2'd2;

    localparam logic [1:0] KIND_LOADB = 2'd0;
    localparam logic [1:0] KIND_EXEC = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [3:0] OP_HALT = 4'h0;
    localparam logic [3:0] OP_SWI = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_BRANCH = 4'h3;
    localparam logic [3:0] OP_XCHG = 4'h4;
    localparam logic [3:0] OP_ARITH = 4'h5;
    localparam logic [3:0] OP_LOGIC = 4'h6;
    localparam logic [3:0] OP_SHIFT = 4'h7;
    localparam logic [3:0] OP_STORE = 4'h8;
    localparam logic [3:0] OP_LOAD = 4'h9;

    localparam logic [3:0] MD_CALL_DIR = 4'd0;
    localparam logic [3:0] MD_CALL_IND = 4'd1;
    localparam logic [3:0] MD_ADD = 4'd0;
    localparam logic [3:0] MD_SUB = 4'd1;
    localparam logic [3:0] MD_MUL = 4'd2;
    localparam logic [3:0] MD_DIV = 4'd3;
    localparam logic [3:0] MD_NOT = 4'd0;
    localparam logic [3:0] MD_AND = 4'd1;
    localparam logic [3:0] MD_OR = 4'd2;
    localparam logic [3:0] MD_XOR = 4'd3;
    localparam logic [3:0] MD_SHL = 4'd0;
    localparam logic [3:0] MD_SHR = 4'd1;
    localparam logic [3:0] MD_ST_BASE = 4'd0;
    localparam logic [3:0] MD_ST_PREINC = 4'd1;
    localparam logic [3:0] MD_ST_IND = 4'd2;
    localparam logic [3:0] MD_LD_CSR = 4'd0;
    localparam logic [3:0] MD_LD_ADDI = 4'd1;
    localparam logic [3:0] MD_LD_IDX = 4'd2;
    localparam logic [3:0] MD_LD_POP = 4'd3;
    localparam logic [3:0] MD_CSR_MOV = 4'd4;
    localparam logic [3:0] MD_CSR_ORI = 4'd5;
    localparam logic [3:0] MD_CSR_IDX = 4'd6;
    localparam logic [3:0] MD_CSR_POP = 4'd7;

    localparam logic [1:0] COND_ALWAYS = 2'd0;
    localparam logic [1:0] COND_EQ = 2'd1;
    localparam logic [1:0] COND_NE = 2'd2;
    localparam logic [1:0] COND_GT = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [4:0]  reg_index;
    } t_in_item;

    typedef struct packed {
        logic        halted;
        logic [31:0] program_counter;
        logic [31:0] read_value;
    } t_out_item;

    typedef enum logic [5:0] {
        DP_NOP, DP_TAKE, DP_LOADB, DP_CLR, DP_X_RI, DP_OUT,
        DP_FETCH_RD, DP_CAP_BE, DP_MEM_RD, DP_CAP_LE, DP_MEM_WR,
        DP_PC_INC4, DP_X_REG, DP_Y_REG, DP_W_REG,
        DP_X_ADD_Y, DP_X_ADD_D, DP_X_SUB4, DP_X_W, DP_X_CSR, DP_X_OR_D, DP_W_STATUS,
        DP_REG_WR_X, DP_REG_WR_Y, DP_REG_WR_W, DP_PC_HANDLER,
        DP_CSR_WR_X, DP_CSR_WR_W, DP_SWI,
        DP_ALU, DP_MUL, DP_DIV_INIT, DP_DIV_STEP, DP_HALT, DP_R0_CLR
    } t_dp_op;

    typedef enum logic [2:0] {SEL_A, SEL_B, SEL_C, SEL_SP, SEL_PC, SEL_RI} t_sel;

    typedef enum logic [2:0] {U_DP, U_RD, U_WR, U_DIV, U_COND, U_END} t_ukind;

    typedef struct packed {
        t_ukind kind;
        t_dp_op op;
        t_sel   sel;
    } t_uop;

    typedef struct packed {
        t_dp_op                op;
        t_sel                  sel;
        logic [ADDR_BITS-1:0]  idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] opcode;
        logic [3:0] mode;
        logic [1:0] kind;
        logic       halted;
        logic       cond_ok;
    } t_dp_stat;

    function automatic t_uop dp(input t_dp_op o, input t_sel s);
        t_uop u;
        u.kind = U_DP;
        u.op = o;
        u.sel = s;
        return u;
    endfunction

    function automatic t_uop ctl(input t_ukind k);
        t_uop u;
        u.kind = k;
        u.op = DP_NOP;
        u.sel = SEL_A;
        return u;
    endfunction

    // Step sequence of one instruction after the fetch.
    function automatic t_uop ucode(input logic [3:0] op, input logic [3:0] md,
                                   input logic [3:0] step);
        t_uop s [16];
        for (int i = 0; i < 16; i++) begin
            s[i] = ctl(U_END);
        end
        s[0] = dp(DP_PC_INC4, SEL_PC);
        case (op)
            OP_HALT: begin
                s[1] = dp(DP_HALT, SEL_A);
            end
            OP_SWI: begin
                s[1] = dp(DP_W_STATUS, SEL_A);
                s[2] = dp(DP_X_REG, SEL_SP);
                s[3] = dp(DP_X_SUB4, SEL_A);
                s[4] = dp(DP_REG_WR_X, SEL_SP);
                s[5] = ctl(U_WR);
                s[6] = dp(DP_W_REG, SEL_PC);
                s[7] = dp(DP_X_REG, SEL_SP);
                s[8] = dp(DP_X_SUB4, SEL_A);
                s[9] = dp(DP_REG_WR_X, SEL_SP);
                s[10] = ctl(U_WR);
                s[11] = dp(DP_SWI, SEL_A);
                s[12] = dp(DP_PC_HANDLER, SEL_A);
            end
            OP_CALL: begin
                if (md == MD_CALL_DIR || md == MD_CALL_IND) begin
                    s[1] = dp(DP_W_REG, SEL_PC);
                    s[2] = dp(DP_X_REG, SEL_SP);
                    s[3] = dp(DP_X_SUB4, SEL_A);
                    s[4] = dp(DP_REG_WR_X, SEL_SP);
                    s[5] = ctl(U_WR);
                    s[6] = dp(DP_X_REG, SEL_A);
                    s[7] = dp(DP_Y_REG, SEL_B);
                    s[8] = dp(DP_X_ADD_Y, SEL_A);
                    s[9] = dp(DP_X_ADD_D, SEL_A);
                    if (md == MD_CALL_DIR) begin
                        s[10] = dp(DP_REG_WR_X, SEL_PC);
                    end else begin
                        s[10] = ctl(U_RD);
                        s[11] = dp(DP_REG_WR_W, SEL_PC);
                    end
                end
            end
            OP_BRANCH: begin
                if (md[2] == 1'b0 && md[1:0] == md[1:0] && (md[3:2] == 2'b00 ||
                        md[3:2] == 2'b10)) begin
                    s[1] = dp(DP_Y_REG, SEL_B);
                    s[2] = dp(DP_W_REG, SEL_C);
                    s[3] = ctl(U_COND);
                    s[4] = dp(DP_X_REG, SEL_A);
                    s[5] = dp(DP_X_ADD_D, SEL_A);
                    if (md[3]) begin
                        s[6] = ctl(U_RD);
                        s[7] = dp(DP_REG_WR_W, SEL_PC);
                    end else begin
                        s[6] = dp(DP_REG_WR_X, SEL_PC);
                    end
                end
            end
            OP_XCHG: begin
                s[1] = dp(DP_Y_REG, SEL_B);
                s[2] = dp(DP_W_REG, SEL_C);
                s[3] = dp(DP_REG_WR_W, SEL_B);
                s[4] = dp(DP_REG_WR_Y, SEL_C);
            end
            OP_ARITH: begin
                if (md[3:2] == 2'b00) begin
                    s[1] = dp(DP_Y_REG, SEL_B);
                    s[2] = dp(DP_W_REG, SEL_C);
                    if (md == MD_MUL) begin
                        s[3] = dp(DP_MUL, SEL_A);
                    end else if (md == MD_DIV) begin
                        s[3] = ctl(U_DIV);
                    end else begin
                        s[3] = dp(DP_ALU, SEL_A);
                    end
                    s[4] = dp(DP_REG_WR_X, SEL_A);
                end
            end
            OP_LOGIC, OP_SHIFT: begin
                if (md[3:2] == 2'b00 && (op == OP_LOGIC || md[1] == 1'b0)) begin
                    s[1] = dp(DP_Y_REG, SEL_B);
                    s[2] = dp(DP_W_REG, SEL_C);
                    s[3] = dp(DP_ALU, SEL_A);
                    s[4] = dp(DP_REG_WR_X, SEL_A);
                end
            end
            OP_STORE: begin
                if (md == MD_ST_PREINC) begin
                    s[1] = dp(DP_X_REG, SEL_A);
                    s[2] = dp(DP_X_ADD_D, SEL_A);
                    s[3] = dp(DP_REG_WR_X, SEL_A);
                    s[4] = dp(DP_W_REG, SEL_C);
                    s[5] = ctl(U_WR);
                end else if (md == MD_ST_BASE || md == MD_ST_IND) begin
                    s[1] = dp(DP_X_REG, SEL_A);
                    s[2] = dp(DP_Y_REG, SEL_B);
                    s[3] = dp(DP_X_ADD_Y, SEL_A);
                    s[4] = dp(DP_X_ADD_D, SEL_A);
                    if (md == MD_ST_BASE) begin
                        s[5] = dp(DP_W_REG, SEL_C);
                        s[6] = ctl(U_WR);
                    end else begin
                        s[5] = ctl(U_RD);
                        s[6] = dp(DP_X_W, SEL_A);
                        s[7] = dp(DP_W_REG, SEL_C);
                        s[8] = ctl(U_WR);
                    end
                end
            end
            OP_LOAD: begin
                case (md)
                    MD_LD_CSR: begin
                        s[1] = dp(DP_X_CSR, SEL_A);
                        s[2] = dp(DP_REG_WR_X, SEL_A);
                    end
                    MD_LD_ADDI: begin
                        s[1] = dp(DP_X_REG, SEL_B);
                        s[2] = dp(DP_X_ADD_D, SEL_A);
                        s[3] = dp(DP_REG_WR_X, SEL_A);
                    end
                    MD_LD_IDX, MD_CSR_IDX: begin
                        s[1] = dp(DP_X_REG, SEL_B);
                        s[2] = dp(DP_Y_REG, SEL_C);
                        s[3] = dp(DP_X_ADD_Y, SEL_A);
                        s[4] = dp(DP_X_ADD_D, SEL_A);
                        s[5] = ctl(U_RD);
                        s[6] = (md == MD_LD_IDX) ? dp(DP_REG_WR_W, SEL_A)
                                                 : dp(DP_CSR_WR_W, SEL_A);
                    end
                    MD_LD_POP, MD_CSR_POP: begin
                        s[1] = dp(DP_X_REG, SEL_B);
                        s[2] = ctl(U_RD);
                        s[3] = (md == MD_LD_POP) ? dp(DP_REG_WR_W, SEL_A)
                                                 : dp(DP_CSR_WR_W, SEL_A);
                        s[4] = dp(DP_X_REG, SEL_B);
                        s[5] = dp(DP_X_ADD_D, SEL_A);
                        s[6] = dp(DP_REG_WR_X, SEL_B);
                    end
                    MD_CSR_MOV: begin
                        s[1] = dp(DP_X_REG, SEL_B);
                        s[2] = dp(DP_CSR_WR_X, SEL_A);
                    end
                    MD_CSR_ORI: begin
                        s[1] = dp(DP_X_CSR, SEL_A);
                        s[2] = dp(DP_X_OR_D, SEL_A);
                        s[3] = dp(DP_CSR_WR_X, SEL_A);
                    end
                    default: begin
                        s[1] = ctl(U_END);
                    end
                endcase
            end
            default: begin
                s[1] = ctl(U_END);
            end
        endcase
        return s[step];
    endfunction

endpackage

// ===== hdl/cie_dp.sv =====
module cie_dp import cie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output t_dp_stat    o_stat,
    output t_out_item   o_out
);

    logic [31:0]          r_gp [0:REG_COUNT-2];
    logic [31:0]          r_csr [0:CSR_COUNT-1];
    logic [31:0]          r_pc;
    logic                 r_halt;
    logic [7:0]           r_mem [0:MEM_SIZE-1];
    logic [7:0]           r_mem_q;
    t_in_item             r_item;
    t_out_item            r_out;
    logic [31:0]          r_ir;
    logic [31:0]          r_x;
    logic [31:0]          r_y;
    logic [31:0]          r_w;
    logic [31:0]          r_rem;

    logic [3:0]           rd_idx;
    logic [31:0]          v_rd;
    logic [31:0]          wr_val;
    logic [31:0]          d_ext;
    logic [3:0]           ir_a;
    logic [3:0]           ir_b;
    logic                 cond_ok;
    logic [31:0]          alu_y;
    logic [32:0]          div_t;
    logic                 div_ge;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [ADDR_BITS-1:0] byte_off;
    logic [7:0]           mem_wdata;

    function automatic logic [31:0] csr_rd(input logic [31:0] c0, input logic [31:0] c1,
                                           input logic [31:0] c2, input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'(CSR_STATUS):  v = c0;
            4'(CSR_HANDLER): v = c1;
            4'(CSR_CAUSE):   v = c2;
            default:         v = '0;
        endcase
        return v;
    endfunction

    assign ir_a = r_ir[23:20];
    assign ir_b = r_ir[19:16];
    assign d_ext = {{20{r_ir[11]}}, r_ir[11:0]};
    assign byte_off = ADDR_BITS'(i_cmd.idx[1:0]);

    always_comb begin
        case (i_cmd.sel)
            SEL_A:   rd_idx = ir_a;
            SEL_B:   rd_idx = ir_b;
            SEL_C:   rd_idx = r_ir[15:12];
            SEL_SP:  rd_idx = SP_IDX;
            SEL_PC:  rd_idx = PC_IDX;
            SEL_RI:  rd_idx = r_item.reg_index[3:0];
            default: rd_idx = PC_IDX;
        endcase
        v_rd = (rd_idx == PC_IDX) ? r_pc : r_gp[rd_idx];

        case (i_cmd.op)
            DP_REG_WR_Y: wr_val = r_y;
            DP_REG_WR_W: wr_val = r_w;
            default:     wr_val = r_x;
        endcase

        case (r_ir[25:24])
            COND_ALWAYS: cond_ok = 1'b1;
            COND_EQ:     cond_ok = (r_y == r_w);
            COND_NE:     cond_ok = (r_y != r_w);
            COND_GT:     cond_ok = ($signed(r_y) > $signed(r_w));
            default:     cond_ok = 1'b0;
        endcase

        alu_y = r_y;
        case (r_ir[31:28])
            OP_ARITH: alu_y = (r_ir[27:24] == MD_SUB) ? r_y - r_w : r_y + r_w;
            OP_LOGIC: begin
                case (r_ir[27:24])
                    MD_NOT:  alu_y = ~r_y;
                    MD_AND:  alu_y = r_y & r_w;
                    MD_OR:   alu_y = r_y | r_w;
                    MD_XOR:  alu_y = r_y ^ r_w;
                    default: alu_y = r_y;
                endcase
            end
            OP_SHIFT: begin
                if (r_w[31:5] != '0) begin
                    alu_y = '0;
                end else if (r_ir[27:24] == MD_SHL) begin
                    alu_y = r_y << r_w[4:0];
                end else begin
                    alu_y = r_y >> r_w[4:0];
                end
            end
            default: alu_y = r_y;
        endcase

        div_t = {r_rem, r_x[31]};
        div_ge = (div_t >= {1'b0, r_w});

        mem_we = 1'b0;
        mem_waddr = r_x[ADDR_BITS-1:0] + byte_off;
        mem_wdata = r_w[{i_cmd.idx[1:0], 3'b000} +: 8];
        case (i_cmd.op)
            DP_CLR: begin
                mem_we = 1'b1;
                mem_waddr = i_cmd.idx;
                mem_wdata = '0;
            end
            DP_LOADB: begin
                mem_we = 1'b1;
                mem_waddr = ADDR_BITS'(r_item.address);
                mem_wdata = r_item.data_byte;
            end
            DP_MEM_WR: mem_we = 1'b1;
            default:   mem_we = 1'b0;
        endcase
        mem_raddr = ((i_cmd.op == DP_FETCH_RD) ? r_pc[ADDR_BITS-1:0] : r_x[ADDR_BITS-1:0])
                    + byte_off;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT - 1; i++) begin
                r_gp[i] <= '0;
            end
            for (int i = 0; i < CSR_COUNT; i++) begin
                r_csr[i] <= '0;
            end
            r_pc <= START_RESET;
            r_halt <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            case (i_cmd.op)
                DP_PC_INC4: r_pc <= r_pc + 32'd4;
                DP_REG_WR_X, DP_REG_WR_Y, DP_REG_WR_W: begin
                    if (rd_idx == PC_IDX) begin
                        r_pc <= wr_val;
                    end else begin
                        r_gp[rd_idx] <= wr_val;
                    end
                end
                DP_PC_HANDLER: r_pc <= r_csr[CSR_HANDLER];
                DP_CSR_WR_X, DP_CSR_WR_W: begin
                    if (ir_a < 4'(CSR_COUNT)) begin
                        r_csr[ir_a[1:0]] <= (i_cmd.op == DP_CSR_WR_W) ? r_w : r_x;
                    end
                end
                DP_SWI: begin
                    r_csr[CSR_CAUSE] <= CAUSE_SWI;
                    r_csr[CSR_STATUS][0] <= 1'b0;
                end
                DP_HALT:   r_halt <= 1'b1;
                DP_R0_CLR: r_gp[0] <= '0;
                default:   r_halt <= r_halt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_TAKE: r_item <= i_item;
            DP_X_RI: begin
                r_x <= r_item.reg_index[4]
                       ? csr_rd(r_csr[0], r_csr[1], r_csr[2], r_item.reg_index[3:0])
                       : v_rd;
            end
            DP_OUT: begin
                r_out.halted <= r_halt;
                r_out.program_counter <= r_pc;
                r_out.read_value <= (r_item.kind == KIND_READ) ? r_x : '0;
            end
            DP_CAP_BE:   r_ir <= {r_ir[23:0], r_mem_q};
            DP_CAP_LE:   r_w[{i_cmd.idx[1:0], 3'b000} +: 8] <= r_mem_q;
            DP_X_REG:    r_x <= v_rd;
            DP_Y_REG:    r_y <= v_rd;
            DP_W_REG:    r_w <= v_rd;
            DP_X_ADD_Y:  r_x <= r_x + r_y;
            DP_X_ADD_D:  r_x <= r_x + d_ext;
            DP_X_SUB4:   r_x <= r_x - 32'd4;
            DP_X_W:      r_x <= r_w;
            DP_X_CSR:    r_x <= csr_rd(r_csr[0], r_csr[1], r_csr[2], ir_b);
            DP_X_OR_D:   r_x <= r_x | d_ext;
            DP_W_STATUS: r_w <= r_csr[CSR_STATUS];
            DP_ALU:      r_x <= alu_y;
            DP_MUL:      r_x <= 32'(r_y * r_w);
            DP_DIV_INIT: begin
                r_x <= r_y;
                r_rem <= '0;
            end
            DP_DIV_STEP: begin
                r_x <= {r_x[30:0], div_ge};
                r_rem <= div_ge ? 32'(div_t - {1'b0, r_w}) : div_t[31:0];
            end
            default: r_x <= r_x;
        endcase
    end

    assign o_stat.opcode = r_ir[31:28];
    assign o_stat.mode = r_ir[27:24];
    assign o_stat.kind = r_item.kind;
    assign o_stat.halted = r_halt;
    assign o_stat.cond_ok = cond_ok;
    assign o_out = r_out;

endmodule

// ===== hdl/cie_ctrl.sv =====
module cie_ctrl import cie_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] BYTE_LAST = 2'd3;
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DISPATCH = 11'b000_0000_0100,
        S_FETCH_A  = 11'b000_0000_1000,
        S_FETCH_D  = 11'b000_0001_0000,
        S_UCODE    = 11'b000_0010_0000,
        S_MRD_A    = 11'b000_0100_0000,
        S_MRD_D    = 11'b000_1000_0000,
        S_MWR      = 11'b001_0000_0000,
        S_DIV      = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_BITS-1:0] r_cnt, n_cnt;
    logic [3:0]           r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    t_uop                 u;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_step = r_step;
        n_out_valid = r_out_valid;
        o_cmd.op = DP_NOP;
        o_cmd.sel = SEL_A;
        o_cmd.idx = r_cnt;
        u = ucode(i_stat.opcode, i_stat.mode, r_step);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLR;
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_TAKE;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = '0;
                n_state = S_FINISH;
                case (i_stat.kind)
                    KIND_LOADB: o_cmd.op = DP_LOADB;
                    KIND_EXEC: begin
                        if (!i_stat.halted) begin
                            n_state = S_FETCH_A;
                        end
                    end
                    KIND_READ: begin
                        o_cmd.op = DP_X_RI;
                        o_cmd.sel = SEL_RI;
                    end
                    default: o_cmd.op = DP_NOP;
                endcase
            end
            S_FETCH_A: begin
                o_cmd.op = DP_FETCH_RD;
                n_state = S_FETCH_D;
            end
            S_FETCH_D: begin
                o_cmd.op = DP_CAP_BE;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[1:0] == BYTE_LAST) begin
                    n_step = '0;
                    n_state = S_UCODE;
                end else begin
                    n_state = S_FETCH_A;
                end
            end
            S_UCODE: begin
                n_step = r_step + 1'b1;
                n_cnt = '0;
                case (u.kind)
                    U_DP: begin
                        o_cmd.op = u.op;
                        o_cmd.sel = u.sel;
                    end
                    U_RD:  n_state = S_MRD_A;
                    U_WR:  n_state = S_MWR;
                    U_DIV: begin
                        o_cmd.op = DP_DIV_INIT;
                        n_state = S_DIV;
                    end
                    U_COND: begin
                        if (!i_stat.cond_ok) begin
                            o_cmd.op = DP_R0_CLR;
                            n_state = S_FINISH;
                        end
                    end
                    default: begin
                        o_cmd.op = DP_R0_CLR;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_MRD_A: begin
                o_cmd.op = DP_MEM_RD;
                n_state = S_MRD_D;
            end
            S_MRD_D: begin
                o_cmd.op = DP_CAP_LE;
                n_cnt = r_cnt + 1'b1;
                n_state = (r_cnt[1:0] == BYTE_LAST) ? S_UCODE : S_MRD_A;
            end
            S_MWR: begin
                o_cmd.op = DP_MEM_WR;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[1:0] == BYTE_LAST) begin
                    n_state = S_UCODE;
                end
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[4:0] == DIV_LAST) begin
                    n_state = S_UCODE;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_step <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_in_ready)
        else $error("Input taken during memory clear.");

    a_finish_raises_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && o_cmd.op == DP_OUT) |=> r_out_valid)
        else $error("Result loaded without output valid.");

    a_halted_skips_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISPATCH && i_stat.kind == KIND_EXEC && i_stat.halted)
        |=> r_state == S_FINISH)
        else $error("Instruction executed while halted.");

endmodule

// ===== hdl/course_isa_instruction_executor.sv =====
// Instructions are fetched byte-serially, data words move a byte at a time, and division uses
// a 32-step divider. Items are handled one at a time: the next is taken in the idle state
// entered when the result is loaded, and a result that waits for the receiver holds the block.
// Reset is synchronous and active low; after it a clearing pass zeroes the 65536 memory bytes,
// one a cycle, before any input.
module course_isa_instruction_executor import cie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cie_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_out       (o_out_item)
    );

endmodule
